>>> rtl/flh_pkg.sv
`default_nettype none

package flh_pkg;

    localparam int unsigned TABLE_MAX = 8;
    localparam int unsigned REG_COUNT = 8;
    localparam int unsigned ADDR_W    = 5;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned DEMAND_W  = 7;
    localparam int unsigned THR_W     = 8;
    localparam int unsigned RPM_W     = 16;
    localparam int unsigned LEVEL_W   = 3;

    typedef logic [DATA_W-1:0]   flh_word_t;
    typedef logic [DEMAND_W-1:0] flh_demand_t;
    typedef logic [THR_W-1:0]    flh_thr_t;
    typedef logic [RPM_W-1:0]    flh_rpm_t;
    typedef logic [LEVEL_W-1:0]  flh_level_t;

    typedef enum logic [2:0] {
        REG_ON_LOW    = 3'd0,
        REG_ON_HIGH   = 3'd1,
        REG_OFF_LOW   = 3'd2,
        REG_OFF_HIGH  = 3'd3,
        REG_SPEED_0_1 = 3'd4,
        REG_SPEED_2_3 = 3'd5,
        REG_SPEED_4_5 = 3'd6,
        REG_SPEED_6_7 = 3'd7
    } flh_reg_idx_t;

    localparam flh_word_t CFG_RESET [REG_COUNT] = '{
        32'd572261888, 32'd1244867879, 32'd437191169, 32'd1043015200,
        32'd196608000, 32'd242486500,  32'd281808800, 32'd353899100
    };

    typedef struct packed {
        logic [TABLE_MAX-1:0][THR_W-1:0] on_thr;
        logic [TABLE_MAX-1:0][THR_W-1:0] off_thr;
        logic [TABLE_MAX-1:0][RPM_W-1:0] rpm;
    } flh_table_t;

    typedef struct packed {
        flh_level_t level;
        flh_rpm_t   rpm;
    } flh_pick_t;

endpackage

`default_nettype wire

>>> rtl/flh_ifs.sv
`default_nettype none

interface flh_demand_if;
    logic                 valid;
    logic                 ready;
    flh_pkg::flh_demand_t demand_percent;

    modport source (output valid, output demand_percent, input ready);
    modport sink   (input valid, input demand_percent, output ready);
endinterface

interface flh_result_if;
    logic                ready;
    logic                valid;
    flh_pkg::flh_rpm_t   target_rpm;
    flh_pkg::flh_level_t selected_level;

    modport source (output valid, output target_rpm, output selected_level, input ready);
    modport sink   (input valid, input target_rpm, input selected_level, output ready);
endinterface

`default_nettype wire

>>> rtl/fan_level_hysteresis_table.sv
// channel  | role   | payload                          | handshake
// demand   | sink   | demand_percent[6:0]              | valid / ready
// result   | source | target_rpm[15:0], selected_level | valid / ready
// apb      | slave  | 8 x 32-bit table registers       | psel / penable, pready tied high
//
// one transaction per cycle sustained while result is ready; a demand taken is held in the
// input register and then shows up as a result from the result register
// level and last demand update as a demand moves into the result register
// a stalled result holds both registers; a new demand is still taken if the
// input register drains in the same cycle
// reset loads the default table and clears level and last demand

`default_nettype none

module fan_level_hysteresis_table #(
    parameter int unsigned LEVEL_COUNT = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [flh_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [flh_pkg::DATA_W-1:0]  pwdata,
    output logic      [flh_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    flh_demand_if.sink                       demand,
    flh_result_if.source                     result
);

    flh_pkg::flh_table_t  table_cfg;
    flh_pkg::flh_pick_t   pick;

    logic                 in_valid_reg;
    flh_pkg::flh_demand_t demand_reg;
    logic                 out_valid_reg;
    flh_pkg::flh_rpm_t    rpm_reg;
    flh_pkg::flh_level_t  level_reg;
    flh_pkg::flh_level_t  level_now_reg;
    flh_pkg::flh_demand_t last_demand_reg;

    logic                 advance;
    logic                 in_take;
    logic                 out_valid_next;
    logic                 in_valid_next;

    flh_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .table_cfg (table_cfg)
    );

    flh_level_pick #(
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_pick (
        .demand      (demand_reg),
        .last_demand (last_demand_reg),
        .level_now   (level_now_reg),
        .table_cfg   (table_cfg),
        .pick        (pick)
    );

    assign advance        = in_valid_reg && (!out_valid_reg || result.ready);
    assign demand.ready   = !in_valid_reg || advance;
    assign in_take        = demand.valid && demand.ready;
    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            level_now_reg   <= '0;
            last_demand_reg <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                level_now_reg   <= pick.level;
                last_demand_reg <= demand_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            demand_reg <= demand.demand_percent;
        end
        if (advance)
        begin
            rpm_reg   <= pick.rpm;
            level_reg <= pick.level;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.target_rpm     = rpm_reg;
    assign result.selected_level = level_reg;

    a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_now_reg <= flh_pkg::LEVEL_W'(LEVEL_COUNT - 1))
        else $error("level beyond table");

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> level_reg == level_now_reg)
        else $error("result level differs from held level");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg && last_demand_reg == $past(demand_reg))
        else $error("transaction lost on its way to the result register");

endmodule

`default_nettype wire

>>> rtl/flh_cfg_regs.sv
`default_nettype none

module flh_cfg_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [flh_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [flh_pkg::DATA_W-1:0]   pwdata,
    output logic      [flh_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    output flh_pkg::flh_table_t               table_cfg
);

    flh_pkg::flh_word_t cfg_reg [flh_pkg::REG_COUNT];
    logic [2:0]         reg_sel;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < int'(flh_pkg::REG_COUNT); i++)
            begin
                cfg_reg[i] <= flh_pkg::CFG_RESET[i];
            end
        end
        else if (wr_en)
        begin
            cfg_reg[reg_sel] <= pwdata;
        end
    end

    always_comb
    begin
        prdata = cfg_reg[reg_sel];
    end

    // unpack the table, level 0 in the lowest byte or half
    assign table_cfg.on_thr  = {cfg_reg[flh_pkg::REG_ON_HIGH], cfg_reg[flh_pkg::REG_ON_LOW]};
    assign table_cfg.off_thr = {cfg_reg[flh_pkg::REG_OFF_HIGH], cfg_reg[flh_pkg::REG_OFF_LOW]};
    assign table_cfg.rpm     = {cfg_reg[flh_pkg::REG_SPEED_6_7], cfg_reg[flh_pkg::REG_SPEED_4_5],
                                cfg_reg[flh_pkg::REG_SPEED_2_3], cfg_reg[flh_pkg::REG_SPEED_0_1]};

endmodule

`default_nettype wire

>>> rtl/flh_level_pick.sv
`default_nettype none

module flh_level_pick #(
    parameter int unsigned LEVEL_COUNT = 8
) (
    input  wire flh_pkg::flh_demand_t demand,
    input  wire flh_pkg::flh_demand_t last_demand,
    input  wire flh_pkg::flh_level_t  level_now,
    input  wire flh_pkg::flh_table_t  table_cfg,
    output flh_pkg::flh_pick_t        pick
);

    localparam flh_pkg::flh_level_t TOP_LEVEL = flh_pkg::LEVEL_W'(LEVEL_COUNT - 1);

    flh_pkg::flh_level_t              cur_level;
    flh_pkg::flh_level_t              down_level;
    flh_pkg::flh_level_t              up_level;
    flh_pkg::flh_level_t              new_level;
    flh_pkg::flh_thr_t                demand_ext;
    logic [flh_pkg::TABLE_MAX-1:0]    above_off;
    logic [flh_pkg::TABLE_MAX-1:0]    reach_on;
    logic                             blocked;

    assign cur_level  = (level_now > TOP_LEVEL) ? TOP_LEVEL : level_now;
    assign demand_ext = flh_pkg::THR_W'(demand);

    always_comb
    begin
        for (int j = 0; j < int'(flh_pkg::TABLE_MAX); j++)
        begin
            above_off[j] = demand_ext > table_cfg.off_thr[j];
            reach_on[j]  = (demand_ext >= table_cfg.on_thr[j]) && (j < int'(LEVEL_COUNT));
        end
    end

    // step down: highest level at or below the current one that holds
    always_comb
    begin
        down_level = '0;
        for (int j = 0; j < int'(flh_pkg::TABLE_MAX); j++)
        begin
            if (j <= int'(cur_level) && above_off[j])
            begin
                down_level = flh_pkg::LEVEL_W'(j);
            end
        end
    end

    // step up: climb while consecutive levels are reached
    always_comb
    begin
        up_level = cur_level;
        blocked  = 1'b0;
        for (int j = 1; j < int'(flh_pkg::TABLE_MAX); j++)
        begin
            if (j > int'(cur_level))
            begin
                if (!blocked && reach_on[j])
                begin
                    up_level = flh_pkg::LEVEL_W'(j);
                end
                else
                begin
                    blocked = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        priority if (demand < last_demand)
        begin
            new_level = down_level;
        end
        else if (demand > last_demand)
        begin
            new_level = up_level;
        end
        else
        begin
            new_level = cur_level;
        end
    end

    assign pick.level = new_level;
    assign pick.rpm   = table_cfg.rpm[new_level];

endmodule

`default_nettype wire

>>> sim/flh_level_checker.sv
`timescale 1ns / 100ps

module flh_level_checker #(
    parameter int unsigned LEVEL_COUNT = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [flh_pkg::ADDR_W-1:0]   paddr,
    input  flh_pkg::flh_word_t           pwdata,
    input  flh_pkg::flh_word_t           prdata,
    input  logic                         demand_valid,
    input  logic                         demand_ready,
    input  flh_pkg::flh_demand_t         demand_percent,
    input  logic                         result_valid,
    input  logic                         result_ready,
    input  flh_pkg::flh_rpm_t            target_rpm,
    input  flh_pkg::flh_level_t          selected_level,
    output int                           failures,
    output int                           picks_pending,
    output int                           demands_taken,
    output int                           results_checked
);
    import flh_pkg::*;

    flh_word_t   table_regs [REG_COUNT];
    flh_level_t  level_now;
    flh_demand_t last_demand;
    flh_pick_t   picks_due [$];
    int          fail_tally = 0;
    int          taken_tally = 0;
    int          checked_tally = 0;

    function automatic int on_thr(input int lv);
        flh_word_t w;
        w = table_regs[REG_ON_LOW + lv / 4];
        return int'(w[THR_W * (lv % 4) +: THR_W]);
    endfunction

    function automatic int off_thr(input int lv);
        flh_word_t w;
        w = table_regs[REG_OFF_LOW + lv / 4];
        return int'(w[THR_W * (lv % 4) +: THR_W]);
    endfunction

    function automatic flh_rpm_t level_rpm(input int lv);
        flh_word_t w;
        w = table_regs[REG_SPEED_0_1 + lv / 2];
        return w[RPM_W * (lv % 2) +: RPM_W];
    endfunction

    // walk down while at or below off thresholds, up while reaching on thresholds
    function automatic flh_pick_t predict_pick(input flh_demand_t d);
        int        lv;
        int        k;
        int        dv;
        bit        climbing;
        flh_pick_t p;
        lv = int'(level_now);
        dv = int'(d);
        if (lv >= LEVEL_COUNT)
            lv = LEVEL_COUNT - 1;
        if (d < last_demand)
        begin
            k = lv + 1;
            while (k > 0 && dv <= off_thr(k - 1))
            begin
                k--;
                lv = (k > 0) ? k - 1 : 0;
            end
        end
        else if (d > last_demand)
        begin
            climbing = 1'b1;
            for (k = lv + 1; k < LEVEL_COUNT && climbing; k++)
            begin
                if (dv >= on_thr(k))
                    lv = k;
                else
                    climbing = 1'b0;
            end
        end
        p.level = flh_level_t'(lv);
        p.rpm   = level_rpm(lv);
        return p;
    endfunction

    task automatic note_failure(input string what);
        fail_tally++;
        if (fail_tally <= 10)
            $display("chk: %s", what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        flh_pick_t    due_pick;
        flh_reg_idx_t idx;
        if (!rst_n)
        begin
            foreach (table_regs[i])
                table_regs[i] = CFG_RESET[i];
            level_now   = '0;
            last_demand = '0;
            picks_due.delete();
        end
        else
        begin
            idx = flh_reg_idx_t'(paddr[ADDR_W-1:2]);
            if (psel && penable && pready)
            begin
                if (pwrite)
                    table_regs[idx] = pwdata;
                else if (prdata !== table_regs[idx])
                    note_failure($sformatf("register %s read: expected %h, got %h",
                                           idx.name(), table_regs[idx], prdata));
            end
            if (result_valid && result_ready)
            begin
                if (picks_due.size() == 0)
                    note_failure($sformatf("result with nothing due: rpm %0d level %0d",
                                           target_rpm, selected_level));
                else
                begin
                    due_pick = picks_due.pop_front();
                    checked_tally++;
                    if (target_rpm !== due_pick.rpm || selected_level !== due_pick.level)
                        note_failure($sformatf(
                            "result %0d: expected rpm %0d level %0d, got rpm %0d level %0d",
                            checked_tally, due_pick.rpm, due_pick.level,
                            target_rpm, selected_level));
                end
            end
            if (demand_valid && demand_ready)
            begin
                due_pick = predict_pick(demand_percent);
                picks_due.push_back(due_pick);
                level_now   = due_pick.level;
                last_demand = demand_percent;
                taken_tally++;
            end
        end
        failures        <= fail_tally;
        picks_pending   <= picks_due.size();
        demands_taken   <= taken_tally;
        results_checked <= checked_tally;
    end

endmodule

>>> sim/fan_level_hysteresis_table_tb.sv
`timescale 1ns / 100ps

module fan_level_hysteresis_table_tb;
    import flh_pkg::*;

    localparam int LEVELS        = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_COUNT   = 10;
    localparam int PHASE_ITEMS   = 160;
    localparam int DIRECTED_LEN  = 22;

    localparam flh_demand_t DIRECTED [DIRECTED_LEN] = '{
        7'd0, 7'd6, 7'd28, 7'd34, 7'd39, 7'd45, 7'd51, 7'd74, 7'd74, 7'd62, 7'd43,
        7'd1, 7'd0, 7'd100, 7'd127, 7'd127, 7'd64, 7'd96, 7'd1, 7'd33, 7'd85, 7'd42
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    flh_word_t           pwdata = '0;
    flh_word_t           prdata;
    logic                pready;
    logic                hold_req = 1'b0;
    int                  recv_stall_pct = 0;
    int                  failures;
    int                  picks_pending;
    int                  demands_taken;
    int                  results_checked;
    int                  reg_writes = 0;
    int                  reg_reads = 0;

    flh_demand_if dem_ch ();
    flh_result_if res_ch ();

    always #6 clk = ~clk;

    fan_level_hysteresis_table #(
        .LEVEL_COUNT(LEVELS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .demand(dem_ch),
        .result(res_ch)
    );

    flh_level_checker #(
        .LEVEL_COUNT(LEVELS)
    ) chk (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .pready(pready),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .demand_valid(dem_ch.valid),
        .demand_ready(dem_ch.ready),
        .demand_percent(dem_ch.demand_percent),
        .result_valid(res_ch.valid),
        .result_ready(res_ch.ready),
        .target_rpm(res_ch.target_rpm),
        .selected_level(res_ch.selected_level),
        .failures(failures),
        .picks_pending(picks_pending),
        .demands_taken(demands_taken),
        .results_checked(results_checked)
    );

    task automatic send_demand(input flh_demand_t d, input int idle_pct);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            dem_ch.valid <= 1'b0;
            @(posedge clk);
        end
        dem_ch.valid          <= 1'b1;
        dem_ch.demand_percent <= d;
        @(posedge clk);
        while (!dem_ch.ready)
            @(posedge clk);
    endtask

    task automatic settle();
        dem_ch.valid <= 1'b0;
        @(posedge clk);
        while (picks_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input flh_reg_idx_t idx, input flh_word_t data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (wr)
            reg_writes++;
        else
            reg_reads++;
    endtask

    task automatic program_table(input flh_table_t t);
        flh_word_t words [REG_COUNT];
        words[REG_ON_LOW]    = t.on_thr[3:0];
        words[REG_ON_HIGH]   = t.on_thr[7:4];
        words[REG_OFF_LOW]   = t.off_thr[3:0];
        words[REG_OFF_HIGH]  = t.off_thr[7:4];
        words[REG_SPEED_0_1] = t.rpm[1:0];
        words[REG_SPEED_2_3] = t.rpm[3:2];
        words[REG_SPEED_4_5] = t.rpm[5:4];
        words[REG_SPEED_6_7] = t.rpm[7:6];
        for (int i = 0; i < REG_COUNT; i++)
            apb_access(1'b1, flh_reg_idx_t'(i), words[i]);
        for (int i = 0; i < REG_COUNT; i++)
            apb_access(1'b0, flh_reg_idx_t'(i), '0);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // rising thresholds with a small hysteresis band, non-decreasing speeds
    function automatic flh_table_t ramp_table();
        flh_table_t t;
        int         on_v;
        int         rpm_v;
        int         band;
        on_v  = $urandom_range(5);
        rpm_v = $urandom_range(2000);
        for (int i = 0; i < TABLE_MAX; i++)
        begin
            band         = (on_v < 10) ? on_v : 10;
            t.on_thr[i]  = flh_thr_t'(on_v);
            t.off_thr[i] = flh_thr_t'(on_v - int'($urandom_range(band)));
            t.rpm[i]     = flh_rpm_t'(rpm_v);
            on_v  += 1 + $urandom_range(14);
            rpm_v += $urandom_range(3000);
        end
        return t;
    endfunction

    function automatic flh_demand_t next_demand(input flh_demand_t prev);
        int pick;
        int v;
        pick = $urandom_range(99);
        if (pick < 15)
            v = int'(prev);
        else if (pick < 55)
        begin
            v = int'(prev) + int'($urandom_range(30)) - 15;
            if (v < 0)
                v = 0;
            if (v > 100)
                v = 100;
        end
        else if (pick < 85)
            v = $urandom_range(100);
        else
            v = $urandom_range(127);
        return flh_demand_t'(v);
    endfunction

    initial
    begin : result_sink
        bit hold_done;
        hold_done    = 1'b0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            res_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((dem_ch.valid && dem_ch.ready) || (res_ch.valid && res_ch.ready)
                || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        flh_demand_t cur;
        flh_table_t  rnd_table;
        int          send_idle;
        dem_ch.valid          = 1'b0;
        dem_ch.demand_percent = '0;
        cur                   = '0;
        send_idle             = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_LEN; i++)
            send_demand(DIRECTED[i], 0);
        cur = DIRECTED[DIRECTED_LEN-1];

        // stall the result side and keep offering demands so that the block backs up
        hold_req <= 1'b1;
        for (int i = 0; i < 24; i++)
        begin
            cur = next_demand(cur);
            send_demand(cur, 0);
        end
        settle();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: ;
                1: program_table('0);
                2: program_table('1);
                8, 9:
                begin
                    rnd_table = {$urandom(), $urandom(), $urandom(), $urandom(),
                                 $urandom(), $urandom(), $urandom(), $urandom()};
                    program_table(rnd_table);
                end
                default: program_table(ramp_table());
            endcase
            case (phase % 4)
                0:
                begin
                    send_idle = 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle = 62;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle = 0;
                    recv_stall_pct <= 62;
                end
                default:
                begin
                    send_idle = 29;
                    recv_stall_pct <= 29;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                cur = next_demand(cur);
                send_demand(cur, send_idle);
            end
            settle();
        end

        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        $display("summary: %0d demands over %0d table settings, %0d results checked",
                 demands_taken, PHASE_COUNT, results_checked);
        $display("summary: %0d register writes, %0d read-backs, one %0d-cycle output hold-off",
                 reg_writes, reg_reads, HOLD_CYCLES);
        if (failures == 0 && picks_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
rtl/flh_pkg.sv
rtl/flh_ifs.sv
rtl/flh_cfg_regs.sv
rtl/flh_level_pick.sv
rtl/fan_level_hysteresis_table.sv
sim/flh_level_checker.sv
sim/fan_level_hysteresis_table_tb.sv
